FILE: rtl/fwt_pkg.sv
package fwt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 52;
    localparam int WAITER_BITS = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FUNC_W      = 9;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 3;

    typedef logic [6:0] t_op;

    localparam t_op OP_WAIT             = 7'd0;
    localparam t_op OP_WAKE             = 7'd1;
    localparam t_op OP_REQUEUE          = 7'd3;
    localparam t_op OP_CMP_REQUEUE      = 7'd4;
    localparam t_op OP_WAKE_OP          = 7'd5;
    localparam t_op OP_LOCK_PI          = 7'd6;
    localparam t_op OP_UNLOCK_PI        = 7'd7;
    localparam t_op OP_TRYLOCK_PI       = 7'd8;
    localparam t_op OP_WAIT_BITSET      = 7'd9;
    localparam t_op OP_WAKE_BITSET      = 7'd10;
    localparam t_op OP_WAIT_REQUEUE_PI  = 7'd11;
    localparam t_op OP_CMP_REQUEUE_PI   = 7'd12;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK     = 3'd0;
    localparam t_status ST_FAULT  = 3'd1;
    localparam t_status ST_AGAIN  = 3'd2;
    localparam t_status ST_NOSYS  = 3'd3;
    localparam t_status ST_NOPROC = 3'd4;
    localparam t_status ST_FULL   = 3'd5;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_SINGLE = 2'd0;
    localparam t_kind KIND_WAIT   = 2'd1;
    localparam t_kind KIND_WAKE   = 2'd2;

    typedef struct packed {
        logic capture;
        logic scan_init;
        logic idx_inc;
        logic insert;
        logic wake_hit;
        logic emit_verdict;
        logic emit_full;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  idx_last;
        logic  slot_used;
        logic  match;
        logic  limit_hit;
        logic  out_free;
        logic  pend_valid;
    } t_stat;

endpackage

FILE: rtl/fwt_ctrl.sv
module fwt_ctrl import fwt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE         = 3'd0;
    localparam logic [2:0] S_DECODE       = 3'd1;
    localparam logic [2:0] S_WAIT_SCAN    = 3'd2;
    localparam logic [2:0] S_WAKE_RD      = 3'd3;
    localparam logic [2:0] S_WAKE_CHK     = 3'd4;
    localparam logic [2:0] S_FINISH       = 3'd5;
    localparam logic [2:0] S_EMIT_VERDICT = 3'd6;
    localparam logic [2:0] S_EMIT_FULL    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.scan_init = 1'b1;
                if (i_stat.kind == KIND_WAIT) begin
                    n_state = S_WAIT_SCAN;
                end else if (i_stat.kind == KIND_WAKE) begin
                    n_state = S_WAKE_RD;
                end else begin
                    n_state = S_EMIT_VERDICT;
                end
            end
            S_WAIT_SCAN: begin
                if (!i_stat.slot_used) begin
                    if (i_stat.out_free) begin
                        o_cmd.insert = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.idx_last) begin
                    n_state = S_EMIT_FULL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_WAKE_RD: begin
                n_state = S_WAKE_CHK;
            end
            S_WAKE_CHK: begin
                if (i_stat.match) begin
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.wake_hit = 1'b1;
                        if (i_stat.limit_hit || i_stat.idx_last) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_WAKE_RD;
                        end
                    end
                end else if (i_stat.idx_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_WAKE_RD;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EMIT_VERDICT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_verdict = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_EMIT_FULL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_full = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/fwt_datapath.sv
module fwt_datapath import fwt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [KEY_BITS-1:0]    i_key_two,
    input  logic                   i_word_read_ok,
    input  logic [WORD_W-1:0]      i_word_now,
    input  logic [WORD_W-1:0]      i_value,
    input  logic                   i_waiter_present,
    input  logic [WAITER_BITS-1:0] i_waiter_id,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_status                o_status,
    output logic                   o_woken_valid,
    output logic [WAITER_BITS-1:0] o_woken_id,
    output logic [IDX_W-1:0]       o_slot,
    output logic [CNT_W-1:0]       o_count,
    output logic                   o_last
);

    logic [FUNC_W-1:0]      r_func;
    logic [KEY_BITS-1:0]    r_key;
    logic [KEY_BITS-1:0]    r_key_two;
    logic                   r_read_ok;
    logic [WORD_W-1:0]      r_word_now;
    logic [WORD_W-1:0]      r_value;
    logic                   r_present;
    logic [WAITER_BITS-1:0] r_wid;

    logic [KEY_BITS-1:0]    r_key_mem [TABLE_DEPTH];
    logic [WAITER_BITS-1:0] r_wid_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]    r_key_q;
    logic [WAITER_BITS-1:0] r_wid_q;
    logic [TABLE_DEPTH-1:0] r_used;

    logic [IDX_W-1:0]       r_idx;
    logic [CNT_W-1:0]       r_woke;
    logic                   r_pend_valid;
    logic [WAITER_BITS-1:0] r_pend_id;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic                   r_out_woken_valid;
    logic [WAITER_BITS-1:0] r_out_woken_id;
    logic [IDX_W-1:0]       r_out_slot;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_last;

    t_op        op;
    t_kind      v_kind;
    t_status    v_status;
    logic       v_limited;
    t_status    word_check;
    logic       word_ok;
    logic [CNT_W-1:0] woke_nx;
    logic       out_free;

    // flag bits 7 and 8 dropped
    assign op      = r_func[6:0];
    assign word_ok = r_read_ok && (r_word_now == r_value);

    always_comb begin
        word_check = !r_read_ok ? ST_FAULT : ST_AGAIN;
    end

    always_comb begin
        v_kind    = KIND_SINGLE;
        v_status  = ST_NOSYS;
        v_limited = 1'b0;
        unique case (op)
            OP_LOCK_PI, OP_UNLOCK_PI, OP_TRYLOCK_PI: begin
                v_status = ST_OK;
            end
            OP_WAKE_OP: begin
                if (r_key == '0) begin
                    v_status = ST_FAULT;
                end else begin
                    v_kind = KIND_WAKE;
                end
            end
            OP_WAIT, OP_WAIT_BITSET, OP_WAIT_REQUEUE_PI: begin
                if (!word_ok) begin
                    v_status = word_check;
                end else if (r_key == '0) begin
                    v_status = ST_FAULT;
                end else if (!r_present) begin
                    v_status = ST_NOPROC;
                end else begin
                    v_kind = KIND_WAIT;
                end
            end
            OP_WAKE, OP_WAKE_BITSET: begin
                if (r_key == '0) begin
                    v_status = ST_FAULT;
                end else begin
                    v_kind    = KIND_WAKE;
                    v_limited = (r_value != '0);
                end
            end
            OP_REQUEUE: begin
                if (r_key_two == '0 || r_key == '0) begin
                    v_status = ST_FAULT;
                end else begin
                    v_kind = KIND_WAKE;
                end
            end
            OP_CMP_REQUEUE, OP_CMP_REQUEUE_PI: begin
                if (!word_ok) begin
                    v_status = word_check;
                end else if (r_key_two == '0 || r_key == '0) begin
                    v_status = ST_FAULT;
                end else begin
                    v_kind = KIND_WAKE;
                end
            end
            default: begin
                v_status = ST_NOSYS;
            end
        endcase
    end

    assign woke_nx  = r_woke + CNT_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.kind       = v_kind;
    assign o_stat.idx_last   = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign o_stat.slot_used  = r_used[r_idx];
    assign o_stat.match      = r_used[r_idx] && (r_key_q == r_key);
    assign o_stat.limit_hit  = v_limited && ({{(WORD_W-CNT_W){1'b0}}, woke_nx} >= r_value);
    assign o_stat.out_free   = out_free;
    assign o_stat.pend_valid = r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_key      <= i_key;
            r_key_two  <= i_key_two;
            r_read_ok  <= i_word_read_ok;
            r_word_now <= i_word_now;
            r_value    <= i_value;
            r_present  <= i_waiter_present;
            r_wid      <= i_waiter_id;
        end
    end

    // slot tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_key_mem[r_idx] <= r_key;
            r_wid_mem[r_idx] <= r_wid;
        end
        r_key_q <= r_key_mem[r_idx];
        r_wid_q <= r_wid_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.insert) begin
            r_used[r_idx] <= 1'b1;
        end else if (i_cmd.wake_hit) begin
            r_used[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_idx  <= '0;
            r_woke <= '0;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.wake_hit) begin
                r_woke <= woke_nx;
            end
        end
    end

    // held woken word, sent once the next one or the end of the scan is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.wake_hit) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wake_hit) begin
            r_pend_id <= r_wid_q;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.insert || i_cmd.emit_verdict || i_cmd.emit_full ||
                     i_cmd.emit_final || (i_cmd.wake_hit && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.insert) begin
            r_out_status      <= ST_OK;
            r_out_woken_valid <= 1'b0;
            r_out_woken_id    <= '0;
            r_out_slot        <= r_idx;
            r_out_count       <= '0;
            r_out_last        <= 1'b1;
        end else if (i_cmd.emit_verdict || i_cmd.emit_full) begin
            r_out_status      <= i_cmd.emit_full ? ST_FULL : v_status;
            r_out_woken_valid <= 1'b0;
            r_out_woken_id    <= '0;
            r_out_slot        <= '0;
            r_out_count       <= '0;
            r_out_last        <= 1'b1;
        end else if (i_cmd.wake_hit && r_pend_valid) begin
            r_out_status      <= ST_OK;
            r_out_woken_valid <= 1'b1;
            r_out_woken_id    <= r_pend_id;
            r_out_slot        <= '0;
            r_out_count       <= r_woke;
            r_out_last        <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_status      <= ST_OK;
            r_out_woken_valid <= r_pend_valid;
            r_out_woken_id    <= r_pend_valid ? r_pend_id : '0;
            r_out_slot        <= '0;
            r_out_count       <= r_woke;
            r_out_last        <= 1'b1;
        end else begin
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_woken_valid = r_out_woken_valid;
    assign o_woken_id    = r_out_woken_id;
    assign o_slot        = r_out_slot;
    assign o_count       = r_out_count;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_woken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_woken_valid |-> r_out_status == ST_OK)
        else $error("woken word with error status");
    a_count_tracks_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_woken_valid == (r_out_count != '0)))
        else $error("count disagrees with woken flag");
    a_not_last_is_woken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_out_woken_valid)
        else $error("non-final word without a woken waiter");
    a_insert_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> !r_used[r_idx])
        else $error("insert into occupied slot");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_count))
        else $error("stalled output word overwritten");
`endif

endmodule

FILE: rtl/futex_wait_table_unit.sv
// single answers pass the decode and verdict states before the output word is registered; a wait
// scans the valid bits one slot per cycle until it finds a free slot or reaches the last slot
// a wake scans the key memory through its one registered read port, ending early once the
// wake limit is reached; output stalls hold each of these
// throughput: one request at a time; the next is taken once the last word is registered
// reset: synchronous active low, clears all slot valid bits at once, no clearing pass
module futex_wait_table_unit import fwt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [KEY_BITS-1:0]    i_key_two,
    input  logic                   i_word_read_ok,
    input  logic [WORD_W-1:0]      i_word_now,
    input  logic [WORD_W-1:0]      i_value,
    input  logic                   i_waiter_present,
    input  logic [WAITER_BITS-1:0] i_waiter_id,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic                   o_woken_valid,
    output logic [WAITER_BITS-1:0] o_woken_id,
    output logic [IDX_W-1:0]       o_slot,
    output logic [CNT_W-1:0]       o_count,
    output logic                   o_last
);

    t_cmd  cmd;
    t_stat stat;

    fwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fwt_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_func           (i_func),
        .i_key            (i_key),
        .i_key_two        (i_key_two),
        .i_word_read_ok   (i_word_read_ok),
        .i_word_now       (i_word_now),
        .i_value          (i_value),
        .i_waiter_present (i_waiter_present),
        .i_waiter_id      (i_waiter_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_woken_valid    (o_woken_valid),
        .o_woken_id       (o_woken_id),
        .o_slot           (o_slot),
        .o_count          (o_count),
        .o_last           (o_last)
    );

endmodule
